// File: hdl/ledscan_pkg.sv
// ----------------------------------------------------------------------------
// ledscan_pkg
// Shared types, sizes and codes for the multiplexed rgb led pwm scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package ledscan_pkg;

   // pwm resolution and blanking
   localparam int PWM_BITS   = 6;
   localparam int DEAD_STEPS = 1;
   localparam int PWM_LEVELS = 1 << PWM_BITS;
   localparam int STEP_WRAP  = PWM_LEVELS + DEAD_STEPS;
   localparam int STEP_W     = $clog2(STEP_WRAP + 1);

   // panel geometry
   localparam int NUM_PIXELS = 60;
   localparam int NUM_BANKS  = 2;
   localparam int NUM_QUADS  = 4;
   localparam int NUM_LEDS   = 5;
   localparam int NUM_THIRDS = 3;
   localparam int QUAD_SPAN  = 15;
   localparam int THIRD_SPAN = 5;
   localparam int ROTATE_BY  = 7 + 30;
   localparam int WORD_W     = 16;
   localparam int PIXEL_W    = 24;
   localparam int MEM_DEPTH  = NUM_BANKS * NUM_PIXELS;
   localparam int MEM_ADDR_W = $clog2(MEM_DEPTH);

   // command codes
   localparam logic [1:0] CMD_TICK  = 2'd0;
   localparam logic [1:0] CMD_WRITE = 2'd1;
   localparam logic [1:0] CMD_SWAP  = 2'd2;

   typedef struct packed {
      logic [1:0] command;
      logic [5:0] pixel_index;
      logic [7:0] red_level;
      logic [7:0] green_level;
      logic [7:0] blue_level;
   } req_type;

   typedef struct packed {
      logic [15:0] sink_word_first;
      logic [15:0] sink_word_second;
      logic [15:0] sink_word_third;
      logic [15:0] sink_word_fourth;
      logic        latch_strobe;
      logic [2:0]  common_drive;
      logic        swap_waiting;
      logic        refused;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic start;
      logic rd_en;
      logic commit;
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic needs_read;
      logic read_last;
      logic rsp_free;
   } dp_status_type;

endpackage

`default_nettype wire

// File: hdl/ledscan_ram.sv
// ----------------------------------------------------------------------------
// ledscan_ram
// Generic single write port, single read port ram with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ledscan_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // storage write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// File: hdl/ledscan_ctrl.sv
// ----------------------------------------------------------------------------
// ledscan_ctrl
// Sequencer: takes one item, runs the pixel read sweep if needed, then
// commits the result into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ledscan_ctrl
   import ledscan_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   input  wire dp_status_type status,
   output ctrl_cmd_type       cmd
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_READ  = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;
   localparam logic [1:0] ST_DONE  = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   assign req_ready = (state_ff == ST_IDLE);

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd.start  = 1'b0;
      cmd.rd_en  = 1'b0;
      cmd.commit = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = status.needs_read ? ST_READ : ST_DONE;
            end
         end
         ST_READ: begin
            cmd.rd_en = 1'b1;
            if (status.read_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (status.rsp_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// File: hdl/ledscan_datapath.sv
// ----------------------------------------------------------------------------
// ledscan_datapath
// Pixel banks, scan counters, bank flags, sink word build-up and the
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ledscan_datapath
   import ledscan_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire req_type      req_data,
   input  wire logic         csr_valid,
   input  wire logic         csr_data,
   input  wire ctrl_cmd_type cmd,
   output dp_status_type     status,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output rsp_type           rsp_data
);

   // bit positions of each led's colors within a sink word
   localparam logic [3:0] RED_BIT   [NUM_LEDS] = '{4'd12, 4'd10, 4'd6, 4'd3, 4'd0};
   localparam logic [3:0] GREEN_BIT [NUM_LEDS] = '{4'd13, 4'd9, 4'd7, 4'd4, 4'd1};
   localparam logic [3:0] BLUE_BIT  [NUM_LEDS] = '{4'd14, 4'd8, 4'd11, 4'd5, 4'd2};

   // scan and bank state
   logic [STEP_W-1:0] step_ff,   step_in;
   logic [1:0]        third_ff,  third_in;
   logic              shown_ff,  shown_in;
   logic              back_ff,   back_in;
   logic [2:0]        common_ff, common_in;
   logic              rotate_ff;

   // item and sweep state
   req_type           item_ff;
   logic [1:0]        quad_ff;
   logic [2:0]        led_ff;
   logic [1:0]        quad_d_ff;
   logic [2:0]        led_d_ff;
   logic              rd_pend_ff;
   logic [WORD_W-1:0] acc_ff [NUM_QUADS];
   logic [MEM_DEPTH-1:0] vld_ff;
   logic              rd_vld_ff;

   // output register
   logic              rsp_valid_ff;
   rsp_type           rsp_data_ff;
   rsp_type           rsp_next;

   logic                  pending;
   logic [5:0]            pos;
   logic [5:0]            pos_map;
   logic [MEM_ADDR_W-1:0] rd_addr;
   logic [MEM_ADDR_W-1:0] wr_addr;
   logic                  wr_en;
   logic [PIXEL_W-1:0]    rd_raw;
   logic [PIXEL_W-1:0]    pixel;
   logic [WORD_W-1:0]     led_bits;
   logic [2:0]            third_step;

   assign pending = (shown_ff == back_ff);

   // status to the sequencer
   assign status.needs_read = (req_data.command == CMD_TICK) &&
                              (step_ff < STEP_W'(PWM_LEVELS));
   assign status.read_last  = (quad_ff == 2'(NUM_QUADS - 1)) &&
                              (led_ff == 3'(NUM_LEDS - 1));
   assign status.rsp_free   = !rsp_valid_ff || rsp_ready;

   // pixel position of the current led, then optional rotation
   assign pos = 6'(2'(NUM_QUADS - 1) - quad_ff) * 6'(QUAD_SPAN) + 6'(led_ff)
                + 6'(third_ff) * 6'(THIRD_SPAN);
   assign pos_map = (rotate_ff == 1'b0) ? pos :
                    (pos >= 6'(ROTATE_BY)) ? pos - 6'(ROTATE_BY) :
                    pos + 6'(NUM_PIXELS - ROTATE_BY);
   assign rd_addr = MEM_ADDR_W'(pos_map) +
                    (shown_ff ? MEM_ADDR_W'(NUM_PIXELS) : MEM_ADDR_W'(0));

   // back bank write on commit of an accepted write
   assign wr_addr = MEM_ADDR_W'(item_ff.pixel_index) +
                    (back_ff ? MEM_ADDR_W'(NUM_PIXELS) : MEM_ADDR_W'(0));
   assign wr_en   = cmd.commit && (item_ff.command == CMD_WRITE) && !pending &&
                    (item_ff.pixel_index < 6'(NUM_PIXELS));

   ledscan_ram #(
      .WIDTH (PIXEL_W),
      .DEPTH (MEM_DEPTH)
   ) u_bank_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data ({item_ff.red_level, item_ff.green_level, item_ff.blue_level}),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );

   // never-written entries read as dark
   assign pixel = rd_vld_ff ? rd_raw : '0;

   // color bits of the led just read
   always_comb begin
      led_bits = '0;
      if (STEP_W'(pixel[23 -: PWM_BITS]) > step_ff) begin
         led_bits[RED_BIT[led_d_ff]] = 1'b1;
      end
      if (STEP_W'(pixel[15 -: PWM_BITS]) > step_ff) begin
         led_bits[GREEN_BIT[led_d_ff]] = 1'b1;
      end
      if (STEP_W'(pixel[7 -: PWM_BITS]) > step_ff) begin
         led_bits[BLUE_BIT[led_d_ff]] = 1'b1;
      end
   end

   // state update and result of the item being committed
   always_comb begin
      step_in    = step_ff;
      third_in   = third_ff;
      shown_in   = shown_ff;
      back_in    = back_ff;
      common_in  = common_ff;
      third_step = 3'(third_ff) + 3'd1;
      rsp_next   = '0;
      unique case (item_ff.command)
         CMD_TICK: begin
            if (step_ff >= STEP_W'(STEP_WRAP)) begin
               step_in = '0;
               if (third_step >= 3'(NUM_THIRDS)) begin
                  third_in = '0;
                  if (pending) begin
                     shown_in = ~shown_ff;
                  end
               end else begin
                  third_in = 2'(third_step);
               end
               common_in = 3'd1 << third_in;
            end else begin
               rsp_next.sink_word_first  = acc_ff[0];
               rsp_next.sink_word_second = acc_ff[1];
               rsp_next.sink_word_third  = acc_ff[2];
               rsp_next.sink_word_fourth = acc_ff[3];
               rsp_next.latch_strobe     = 1'b1;
               step_in = step_ff + STEP_W'(1);
               if (step_ff >= STEP_W'(PWM_LEVELS)) begin
                  common_in = '0;
               end
            end
         end
         CMD_WRITE: begin
            rsp_next.refused = pending;
         end
         CMD_SWAP: begin
            rsp_next.refused = pending;
            if (!pending) begin
               back_in = ~back_ff;
            end
         end
         default: begin
         end
      endcase
      rsp_next.common_drive = common_in;
      rsp_next.swap_waiting = (shown_in == back_in);
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= '0;
         third_ff     <= '0;
         shown_ff     <= 1'b1;
         back_ff      <= 1'b0;
         common_ff    <= '0;
         rotate_ff    <= 1'b0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         vld_ff       <= '0;
      end else begin
         if (csr_valid) begin
            rotate_ff <= csr_data;
         end
         if (cmd.commit) begin
            step_ff   <= step_in;
            third_ff  <= third_in;
            shown_ff  <= shown_in;
            back_ff   <= back_in;
            common_ff <= common_in;
         end
         if (wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
         rd_pend_ff <= cmd.rd_en;
         if (cmd.commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // item capture, sweep counters and word build-up
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         item_ff <= req_data;
         quad_ff <= '0;
         led_ff  <= '0;
         for (int q = 0; q < NUM_QUADS; q++) begin
            acc_ff[q] <= '0;
         end
      end else begin
         if (cmd.rd_en) begin
            if (led_ff == 3'(NUM_LEDS - 1)) begin
               led_ff  <= '0;
               quad_ff <= quad_ff + 2'd1;
            end else begin
               led_ff <= led_ff + 3'd1;
            end
         end
         if (rd_pend_ff) begin
            acc_ff[quad_d_ff] <= acc_ff[quad_d_ff] | led_bits;
         end
      end
      if (cmd.rd_en) begin
         quad_d_ff <= quad_ff;
         led_d_ff  <= led_ff;
         rd_vld_ff <= vld_ff[rd_addr];
      end
      if (cmd.commit) begin
         rsp_data_ff <= rsp_next;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// File: hdl/multiplexed_rgb_led_pwm_scanner_unit.sv
// ----------------------------------------------------------------------------
// multiplexed_rgb_led_pwm_scanner_unit
// Scan driver for 60 rgb leds in three multiplexed thirds, double banked.
// ----------------------------------------------------------------------------
// Lit-step scan tick: after accept the sequencer runs ST_READ, ST_DRAIN and ST_DONE; the 20 pixel
// reads go one per cycle through the bank ram port, and ST_DONE commits once the output register is free.
// Wrap tick, dead step, write, swap: straight to ST_DONE; no new item is taken until the sequencer is in ST_IDLE.
// A waiting result does not block acceptance of the next item.
// Synchronous reset clears counters, bank flags and pixel valid bits, so all
// pixels read dark; rotation is off and all commons are off after reset.
`default_nettype none

module multiplexed_rgb_led_pwm_scanner_unit
   import ledscan_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data,
   input  wire logic    csr_valid,
   output logic         csr_ready,
   input  wire logic    csr_data
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   assign csr_ready = 1'b1;

   ledscan_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   ledscan_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // at most one common is ever on
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot0(rsp_data.common_drive))
      else $error("common drive not one-hot");

   // no words latched without a strobe
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.latch_strobe) |->
         (rsp_data.sink_word_first == 16'd0 && rsp_data.sink_word_second == 16'd0 &&
          rsp_data.sink_word_third == 16'd0 && rsp_data.sink_word_fourth == 16'd0))
      else $error("sink words set without latch strobe");

   // a refusal only happens with a swap still waiting and never latches
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.refused) |->
         (rsp_data.swap_waiting && !rsp_data.latch_strobe))
      else $error("refusal without waiting swap");

   // bit 15 of a sink word has no led
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.sink_word_first[15] || rsp_data.sink_word_second[15] ||
                      rsp_data.sink_word_third[15] || rsp_data.sink_word_fourth[15]))
      else $error("unused sink word bit set");

endmodule

`default_nettype wire

// File: sim/multiplexed_rgb_led_pwm_scanner_unit_test.sv
// ----------------------------------------------------------------------------
// multiplexed_rgb_led_pwm_scanner_unit_test
// Drives pixel writes, bank swaps and scan ticks into the led scanner with
// random bursts and output stalls, predicts every result from a behavioral
// copy of the banks and scan counters, and checks each result field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module multiplexed_rgb_led_pwm_scanner_unit_test;
   import ledscan_pkg::*;

   localparam logic [1:0] CMD_IDLE = 2'd3;

   localparam int RESET_CYCLES   = 7;
   localparam int SETTLE_CYCLES  = 30;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int SESSIONS       = 7;
   localparam int SESSION_ITEMS  = 250;
   localparam int MAX_REPORTS    = 60;

   // led bit positions in a sink word, element 0 is led 0 of the quadrant
   localparam logic [4:0][3:0] RED_POS   = {4'd0, 4'd3, 4'd6, 4'd10, 4'd12};
   localparam logic [4:0][3:0] GREEN_POS = {4'd1, 4'd4, 4'd7, 4'd9, 4'd13};
   localparam logic [4:0][3:0] BLUE_POS  = {4'd2, 4'd5, 4'd11, 4'd8, 4'd14};

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic    csr_valid = 1'b0;
   logic    csr_ready;
   logic    csr_data  = 1'b0;

   // predicted panel state
   logic [PIXEL_W-1:0] bank_mem [MEM_DEPTH];
   logic [STEP_W-1:0]  scan_step;
   logic [1:0]         active_third;
   logic               shown_bank;
   logic               back_bank;
   logic [2:0]         commons;
   logic               rotate_on;

   req_type cmd_backlog[$];
   rsp_type awaited_outputs[$];
   int      fail_count  = 0;
   int      idle_cycles = 0;

   multiplexed_rgb_led_pwm_scanner_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // expected output for one item, advancing the predicted state
   function automatic rsp_type panel_response(input req_type item);
      rsp_type                        res;
      logic                           pending;
      int                             p;
      logic [PIXEL_W-1:0]             px;
      logic [NUM_QUADS-1:0][WORD_W-1:0] words;
      res     = '0;
      words   = '0;
      pending = (shown_bank == back_bank);
      case (item.command)
         CMD_TICK: begin
            if (scan_step >= STEP_WRAP) begin
               // wrap: next third, frame end takes a waiting swap
               scan_step = '0;
               if (active_third == NUM_THIRDS - 1) begin
                  active_third = '0;
                  if (shown_bank == back_bank) shown_bank = ~shown_bank;
               end else begin
                  active_third = active_third + 1'b1;
               end
               commons = 3'b001 << active_third;
            end else begin
               if (scan_step < PWM_LEVELS) begin
                  for (int q = 0; q < NUM_QUADS; q++) begin
                     for (int i = 0; i < NUM_LEDS; i++) begin
                        p = (3 - q) * QUAD_SPAN + i + int'(active_third) * THIRD_SPAN;
                        if (rotate_on)
                           p = (p >= ROTATE_BY) ? p - ROTATE_BY : p + NUM_PIXELS - ROTATE_BY;
                        px = bank_mem[int'(shown_bank) * NUM_PIXELS + p];
                        if (px[23 -: PWM_BITS] > scan_step) words[q][RED_POS[i]] = 1'b1;
                        if (px[15 -: PWM_BITS] > scan_step) words[q][GREEN_POS[i]] = 1'b1;
                        if (px[7 -: PWM_BITS] > scan_step) words[q][BLUE_POS[i]] = 1'b1;
                     end
                  end
               end
               res.latch_strobe = 1'b1;
               scan_step = scan_step + 1'b1;
               // a dead step blanks the commons
               if (scan_step > PWM_LEVELS) commons = '0;
            end
         end
         CMD_WRITE: begin
            if (pending)
               res.refused = 1'b1;
            else if (item.pixel_index < NUM_PIXELS)
               bank_mem[int'(back_bank) * NUM_PIXELS + int'(item.pixel_index)] =
                  {item.red_level, item.green_level, item.blue_level};
         end
         CMD_SWAP: begin
            if (pending) res.refused = 1'b1;
            else back_bank = ~back_bank;
         end
         default: begin
         end
      endcase
      res.sink_word_first  = words[0];
      res.sink_word_second = words[1];
      res.sink_word_third  = words[2];
      res.sink_word_fourth = words[3];
      res.common_drive     = commons;
      res.swap_waiting     = (shown_bank == back_bank);
      return res;
   endfunction

   function automatic void push_item(input logic [1:0] cmd, input logic [5:0] idx,
                                     input logic [7:0] r, input logic [7:0] g,
                                     input logic [7:0] b);
      req_type item;
      item.command     = cmd;
      item.pixel_index = idx;
      item.red_level   = r;
      item.green_level = g;
      item.blue_level  = b;
      cmd_backlog.push_back(item);
   endfunction

   // levels biased toward dark, full and the lowest thresholds
   function automatic logic [7:0] pick_level();
      case ($urandom_range(0, 4))
         0: return 8'h00;
         1: return 8'hFF;
         2: return 8'($urandom_range(0, 7));
         default: return 8'($urandom);
      endcase
   endfunction

   // write batches, swaps and long tick runs, with some noise mixed in
   task automatic queue_session(input int count);
      int n;
      int queued;
      queued = 0;
      while (queued < count) begin
         n = $urandom_range(1, 24);
         if (n > count - queued) n = count - queued;
         repeat (n) begin
            push_item(CMD_WRITE,
                      ($urandom_range(0, 9) == 0) ? 6'($urandom_range(60, 63))
                                                  : 6'($urandom_range(0, 59)),
                      pick_level(), pick_level(), pick_level());
         end
         queued += n;
         if (queued < count && $urandom_range(0, 4) != 0) begin
            push_item(CMD_SWAP, 6'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
            queued++;
         end
         n = $urandom_range(40, 160);
         if (n > count - queued) n = count - queued;
         repeat (n) begin
            if ($urandom_range(0, 19) == 0)
               push_item(2'($urandom), 6'($urandom), 8'($urandom), 8'($urandom),
                         8'($urandom));
            else
               push_item(CMD_TICK, 6'($urandom), 8'($urandom), 8'($urandom),
                         8'($urandom));
         end
         queued += n;
      end
   endtask

   task automatic write_rotate(input logic value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      csr_valid <= 1'b0;
      rotate_on = value;
   endtask

   // hold until every queued item is in and every result is out
   task automatic wait_drained();
      while (cmd_backlog.size() != 0 || req_valid || awaited_outputs.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic log_failure(input string msg);
      if (fail_count < MAX_REPORTS) $display("mismatch at %0t: %s", $time, msg);
      fail_count++;
   endtask

   // main sequence
   initial begin
      foreach (bank_mem[k]) bank_mem[k] = '0;
      scan_step    = '0;
      active_third = '0;
      shown_bank   = 1'b1;
      back_bank    = 1'b0;
      commons      = '0;
      rotate_on    = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      write_rotate(1'b0);

      // dark panel right after reset, commons still off
      push_item(CMD_TICK, 6'd0, 8'h00, 8'h00, 8'h00);
      // extremes of levels and pixel range
      push_item(CMD_WRITE, 6'd0, 8'hFF, 8'hFF, 8'hFF);
      push_item(CMD_WRITE, 6'd59, 8'h80, 8'h04, 8'h03);
      push_item(CMD_WRITE, 6'd37, 8'h00, 8'hFC, 8'h7F);
      push_item(CMD_WRITE, 6'd36, 8'h55, 8'hAA, 8'h01);
      // positions past the panel are dropped, not refused
      push_item(CMD_WRITE, 6'd60, 8'hFF, 8'hFF, 8'hFF);
      push_item(CMD_WRITE, 6'd63, 8'hFF, 8'hFF, 8'hFF);
      // unused command code does nothing
      push_item(CMD_IDLE, 6'd63, 8'hFF, 8'hFF, 8'hFF);
      push_item(CMD_TICK, 6'd63, 8'hFF, 8'hFF, 8'hFF);
      push_item(CMD_SWAP, 6'd0, 8'h00, 8'h00, 8'h00);
      // both refused while the swap waits for frame end
      push_item(CMD_WRITE, 6'd1, 8'hFF, 8'hFF, 8'hFF);
      push_item(CMD_SWAP, 6'd0, 8'h00, 8'h00, 8'h00);
      push_item(CMD_IDLE, 6'd0, 8'h00, 8'h00, 8'h00);
      repeat (8) push_item(CMD_TICK, 6'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      wait_drained();

      for (int s = 0; s < SESSIONS; s++) begin
         // session three skips the rotation write and keeps the rotation of session two
         if (s != 3) write_rotate((s % 2) == 0);
         queue_session(SESSION_ITEMS);
         wait_drained();
      end

      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   // driver: bursts of items with random gaps, prediction on accept
   int burst_left;
   int gap_left;
   always @(posedge clock) begin
      if (reset) begin
         req_valid  <= 1'b0;
         burst_left <= $urandom_range(1, 40);
         gap_left   <= 0;
      end else begin
         if (req_valid && req_ready) awaited_outputs.push_back(panel_response(req_data));
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left  <= gap_left - 1;
               req_valid <= 1'b0;
            end else if (cmd_backlog.size() != 0) begin
               req_valid <= 1'b1;
               req_data  <= cmd_backlog.pop_front();
               if (burst_left > 1) begin
                  burst_left <= burst_left - 1;
               end else begin
                  burst_left <= $urandom_range(1, 40);
                  gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: check results against the oldest prediction, stall in modes
   rsp_type    due;
   logic [5:0] stall_tick;
   logic [1:0] stall_mode;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_tick <= '0;
         stall_mode <= '0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (awaited_outputs.size() == 0) begin
               log_failure($sformatf("result %h arrived with none awaited", rsp_data));
            end else begin
               due = awaited_outputs.pop_front();
               if (rsp_data.sink_word_first !== due.sink_word_first)
                  log_failure($sformatf("sink_word_first %h, want %h",
                                        rsp_data.sink_word_first, due.sink_word_first));
               if (rsp_data.sink_word_second !== due.sink_word_second)
                  log_failure($sformatf("sink_word_second %h, want %h",
                                        rsp_data.sink_word_second, due.sink_word_second));
               if (rsp_data.sink_word_third !== due.sink_word_third)
                  log_failure($sformatf("sink_word_third %h, want %h",
                                        rsp_data.sink_word_third, due.sink_word_third));
               if (rsp_data.sink_word_fourth !== due.sink_word_fourth)
                  log_failure($sformatf("sink_word_fourth %h, want %h",
                                        rsp_data.sink_word_fourth, due.sink_word_fourth));
               if (rsp_data.latch_strobe !== due.latch_strobe)
                  log_failure($sformatf("latch_strobe %b, want %b",
                                        rsp_data.latch_strobe, due.latch_strobe));
               if (rsp_data.common_drive !== due.common_drive)
                  log_failure($sformatf("common_drive %b, want %b",
                                        rsp_data.common_drive, due.common_drive));
               if (rsp_data.swap_waiting !== due.swap_waiting)
                  log_failure($sformatf("swap_waiting %b, want %b",
                                        rsp_data.swap_waiting, due.swap_waiting));
               if (rsp_data.refused !== due.refused)
                  log_failure($sformatf("refused %b, want %b",
                                        rsp_data.refused, due.refused));
            end
         end
         stall_tick <= stall_tick + 1'b1;
         if (stall_tick == '1) stall_mode <= 2'($urandom_range(0, 3));
         case (stall_mode)
            2'd0: rsp_ready <= 1'b1;
            2'd1: rsp_ready <= 1'($urandom_range(0, 1));
            2'd2: rsp_ready <= (stall_tick[1:0] == 2'd0);
            default: rsp_ready <= (stall_tick[2:0] != 3'd7);
         endcase
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
         $display("Regression FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule

`default_nettype wire
